[rtl/qdd_pkg.sv]
`default_nettype none

package qdd_pkg;

	// command codes carried by an input transaction
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_APPLY  = 2'd1;
	localparam logic [1:0] CMD_LOAD   = 2'd2;

	// configuration register indexes
	localparam logic CFG_VALUE_MIN = 1'b0;
	localparam logic CFG_VALUE_MAX = 1'b1;

	// configuration reset values
	localparam logic signed [15:0] VALUE_MIN_RST = 16'sd0;
	localparam logic signed [15:0] VALUE_MAX_RST = 16'sd127;

	// legal single transitions, bit n for code n (prev pair, current pair)
	localparam logic [15:0] LEGAL_MOVE = 16'b0110_1001_1001_0110;

	// history patterns that complete one detent
	localparam logic [7:0] HIST_CCW = 8'h2b;
	localparam logic [7:0] HIST_CW  = 8'h17;

	// step encodings
	localparam logic signed [1:0] STEP_NONE = 2'sd0;
	localparam logic signed [1:0] STEP_CW   = 2'sd1;
	localparam logic signed [1:0] STEP_CCW  = -2'sd1;

	// decoder state
	typedef struct packed {
		logic [3:0]         phase_code;
		logic [7:0]         valid_history;
		logic signed [1:0]  step_pending;
		logic signed [15:0] count_value;
	} qdd_state_t;

endpackage

`default_nettype wire

[rtl/qdd_in_if.sv]
`default_nettype none

interface qdd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic               pin_a;
	logic               pin_b;
	logic signed [15:0] load_value;

	modport source (output valid, output command, output pin_a, output pin_b,
		output load_value, input ready);
	modport sink (input valid, input command, input pin_a, input pin_b,
		input load_value, output ready);
endinterface

`default_nettype wire

[rtl/qdd_out_if.sv]
`default_nettype none

interface qdd_out_if;
	logic               valid;
	logic               ready;
	logic signed [1:0]  pending_step;
	logic signed [15:0] current_value;

	modport source (output valid, output pending_step, output current_value,
		input ready);
	modport sink (input valid, input pending_step, input current_value,
		output ready);
endinterface

`default_nettype wire

[rtl/quadrature_detent_decoder_core.sv]
`default_nettype none

// pipeline: the input register captures an accepted transaction, and stage 1
//   moves into the result register once that register is free
// throughput: one transaction per cycle while the result side is ready; the state update is a single
//   table lookup and 17-bit add/compare between the input and result registers
// reset: arst_n clears decoder state, pipeline valids and the result register,
//   and sets value_min to 0 and value_max to 127

module quadrature_detent_decoder_core import qdd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	qdd_in_if.sink             in_ch,
	qdd_out_if.source          out_ch,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	logic                valid_s1;
	logic [1:0]          command_s1;
	logic                pin_a_s1;
	logic                pin_b_s1;
	logic signed [15:0]  load_value_s1;
	logic                out_valid_q;
	logic signed [1:0]   pending_step_q;
	logic signed [15:0]  current_value_q;
	logic signed [15:0]  value_min_q;
	logic signed [15:0]  value_max_q;
	qdd_state_t          state_q;
	qdd_state_t          state_next;
	logic                advance;

	// stage 1 moves into the result register when that register is free
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_min_q <= VALUE_MIN_RST;
			value_max_q <= VALUE_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VALUE_MIN: value_min_q <= cfg_data;
				CFG_VALUE_MAX: value_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			command_s1    <= in_ch.command;
			pin_a_s1      <= in_ch.pin_a;
			pin_b_s1      <= in_ch.pin_b;
			load_value_s1 <= in_ch.load_value;
		end
	end

	// decoder state update
	qdd_step u_step (
		.state      (state_q),
		.command    (command_s1),
		.pin_a      (pin_a_s1),
		.pin_b      (pin_b_s1),
		.load_value (load_value_s1),
		.value_min  (value_min_q),
		.value_max  (value_max_q),
		.state_next (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_step_q  <= STEP_NONE;
			current_value_q <= '0;
		end else if (advance) begin
			pending_step_q  <= state_next.step_pending;
			current_value_q <= state_next.count_value;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.pending_step  = pending_step_q;
	assign out_ch.current_value = current_value_q;

	// the pending step never holds the unused code
	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step_pending != 2'b10)
		else $error("pending step holds an illegal code");

	// a stalled result with a full input stage blocks new transactions
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready && valid_s1) |-> !in_ch.ready)
		else $error("input accepted while both stages are blocked");

	// a load clears the phase tracking and reports the loaded count
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && command_s1 == CMD_LOAD) |=>
		(state_q.valid_history == 8'h00 && state_q.phase_code == 4'h0
		&& out_ch.current_value == $past(load_value_s1)))
		else $error("load did not clear state or set count");

	// an applied step only ever lands inside the configured range
	a_apply_range: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && command_s1 == CMD_APPLY
		&& state_next.count_value != state_q.count_value) |->
		(state_next.count_value >= value_min_q
		&& state_next.count_value <= value_max_q))
		else $error("applied step left the configured range");

	// result payload only changes when a new result is loaded
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(current_value_q) && $stable(pending_step_q))
		else $error("result changed without a new transaction");

endmodule

`default_nettype wire

[rtl/qdd_step.sv]
`default_nettype none

module qdd_step import qdd_pkg::*; (
	input  qdd_state_t         state,
	input  logic [1:0]         command,
	input  logic               pin_a,
	input  logic               pin_b,
	input  logic signed [15:0] load_value,
	input  logic signed [15:0] value_min,
	input  logic signed [15:0] value_max,
	output qdd_state_t         state_next
);

	logic [3:0]         code;
	logic [7:0]         history;
	logic signed [16:0] sum;
	logic               in_range;

	// shift in the new phase pair and extend the history
	assign code    = {state.phase_code[1:0], pin_a, pin_b};
	assign history = {state.valid_history[3:0], code};

	// candidate count after the pending step, no wrap
	assign sum      = {state.count_value[15], state.count_value}
		+ {{15{state.step_pending[1]}}, state.step_pending};
	assign in_range = (sum <= $signed({value_max[15], value_max}))
		&& (sum >= $signed({value_min[15], value_min}));

	// next state per command
	always_comb begin
		state_next = state;
		unique case (command)
			CMD_SAMPLE: begin
				state_next.phase_code = code;
				if (LEGAL_MOVE[code]) begin
					state_next.valid_history = history;
					if (history == HIST_CCW) begin
						state_next.step_pending = STEP_CCW;
					end else if (history == HIST_CW) begin
						state_next.step_pending = STEP_CW;
					end
				end else begin
					// bounce drops the pending step
					state_next.step_pending = STEP_NONE;
				end
			end
			CMD_APPLY: begin
				if (in_range) begin
					state_next.count_value  = sum[15:0];
					state_next.step_pending = STEP_NONE;
				end
			end
			CMD_LOAD: begin
				state_next.count_value   = load_value;
				state_next.valid_history = '0;
				state_next.phase_code    = '0;
				state_next.step_pending  = STEP_NONE;
			end
			default: begin
				state_next = state;
			end
		endcase
	end

endmodule

`default_nettype wire

[verif/quadrature_detent_decoder_core_tb.sv]
`timescale 1ns / 100ps

module quadrature_detent_decoder_core_tb;
	import qdd_pkg::*;

	// the fourth command code does nothing but report the state
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// legal single transitions, bit n for code n
	localparam bit [15:0] LEGAL_CODES = 16'h6996;
	localparam bit [7:0]  CCW_PATTERN = 8'h2b;
	localparam bit [7:0]  CW_PATTERN  = 8'h17;

	localparam int QUIET_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 100;
	localparam int PHASE_ITEMS  = 290;

	typedef struct packed {
		logic [1:0]  command;
		logic        pin_a;
		logic        pin_b;
		logic [15:0] load_value;
	} enc_item_t;

	typedef struct packed {
		logic signed [1:0]  pending_step;
		logic signed [15:0] current_value;
	} enc_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	// for config rows a carries the register index and data the value
	typedef struct packed {
		row_kind_e          kind;
		logic [1:0]         cmd;
		logic               a;
		logic               b;
		logic [15:0]        data;
		logic               typed;
		logic signed [1:0]  want_step;
		logic signed [15:0] want_value;
	} dir_row_t;

	localparam dir_row_t DIRECTED [35] = '{
		// kind      cmd         a     b     data        typed step    value
		// out of reset, spare command and apply with nothing pending
		'{ROW_ITEM, CMD_SPARE,  1'b1, 1'b1, 16'h7fff, 1'b1, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b1, 1'b0, 16'h8000, 1'b1, 2'sd0,  16'sd0},
		// one clockwise detent, then apply
		'{ROW_ITEM, CMD_SAMPLE, 1'b0, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b0, 1'b0, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		// count loaded below the range, a step brings it back in
		'{ROW_ITEM, CMD_LOAD,   1'b1, 1'b1, 16'hffff, 1'b1, 2'sd0,  16'shffff},
		'{ROW_ITEM, CMD_SAMPLE, 1'b0, 1'b1, 16'hffff, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b1, 1'b1, 16'h5555, 1'b0, 2'sd0,  16'sd0},
		// counter-clockwise at the floor is refused, then bounce clears it
		'{ROW_ITEM, CMD_LOAD,   1'b0, 1'b1, 16'h0000, 1'b1, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b0, 16'haaaa, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b0, 1'b0, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b0, 1'b0, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		// clockwise at the ceiling is refused
		'{ROW_ITEM, CMD_LOAD,   1'b1, 1'b0, 16'h007f, 1'b1, 2'sd0,  16'sd127},
		'{ROW_ITEM, CMD_SAMPLE, 1'b0, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b0, 1'b0, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		// full range: no wrap at either end of the count
		'{ROW_CFG,  2'd0, CFG_VALUE_MIN, 1'b0, 16'h8000, 1'b0, 2'sd0, 16'sd0},
		'{ROW_CFG,  2'd0, CFG_VALUE_MAX, 1'b0, 16'h7fff, 1'b0, 2'sd0, 16'sd0},
		'{ROW_ITEM, CMD_LOAD,   1'b0, 1'b0, 16'h7fff, 1'b1, 2'sd0,  16'sh7fff},
		'{ROW_ITEM, CMD_SAMPLE, 1'b0, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b0, 1'b0, 16'h0000, 1'b1, 2'sd1,  16'sh7fff},
		'{ROW_ITEM, CMD_LOAD,   1'b1, 1'b1, 16'h8000, 1'b1, 2'sd0,  16'sh8000},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b0, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b0, 1'b0, 16'h0000, 1'b1, -2'sd1, 16'sh8000},
		// empty range: nothing is ever applied
		'{ROW_CFG,  2'd0, CFG_VALUE_MIN, 1'b0, 16'h0005, 1'b0, 2'sd0, 16'sd0},
		'{ROW_CFG,  2'd0, CFG_VALUE_MAX, 1'b0, 16'h0004, 1'b0, 2'sd0, 16'sd0},
		'{ROW_ITEM, CMD_LOAD,   1'b0, 1'b0, 16'h0004, 1'b1, 2'sd0,  16'sd4},
		'{ROW_ITEM, CMD_SAMPLE, 1'b0, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SAMPLE, 1'b1, 1'b1, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_APPLY,  1'b0, 1'b0, 16'h0000, 1'b0, 2'sd0,  16'sd0},
		'{ROW_ITEM, CMD_SPARE,  1'b0, 1'b0, 16'h0000, 1'b0, 2'sd0,  16'sd0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	qdd_in_if  in_if();
	qdd_out_if out_if();

	quadrature_detent_decoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// decoder state as the predictor sees it
	logic [3:0]         code_reg;
	logic [7:0]         hist_reg;
	logic signed [1:0]  step_reg;
	logic signed [15:0] count_reg;
	logic signed [15:0] lim_lo;
	logic signed [15:0] lim_hi;

	enc_result_t predicted_readings [$];
	logic [1:0]  walk_pair;
	int          pace_ctr;
	int          fault_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predict the reading after one item and advance the state
	function automatic enc_result_t decode_item(enc_item_t it);
		logic [3:0]         code;
		logic signed [16:0] sum;
		enc_result_t        r;
		case (it.command)
			CMD_SAMPLE: begin
				code = {code_reg[1:0], it.pin_a, it.pin_b};
				code_reg = code;
				if (LEGAL_CODES[code]) begin
					hist_reg = {hist_reg[3:0], code};
					if (hist_reg == CCW_PATTERN)
						step_reg = -2'sd1;
					else if (hist_reg == CW_PATTERN)
						step_reg = 2'sd1;
				end else begin
					// bounce drops whatever step was pending
					step_reg = 2'sd0;
				end
			end
			CMD_APPLY: begin
				sum = count_reg + step_reg;
				if (sum >= lim_lo && sum <= lim_hi) begin
					count_reg = sum[15:0];
					step_reg = 2'sd0;
				end
			end
			CMD_LOAD: begin
				count_reg = it.load_value;
				hist_reg = '0;
				code_reg = '0;
				step_reg = 2'sd0;
			end
			default: ;
		endcase
		r.pending_step = step_reg;
		r.current_value = count_reg;
		return r;
	endfunction

	// offer one transaction after a random gap, queue its expected reading
	task automatic send_item(enc_item_t it, bit typed, enc_result_t want);
		int gap;
		gap = (pace_ctr % 200 < 50) ? 0 : $urandom_range(0, 6);
		pace_ctr++;
		if (gap != 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.command <= it.command;
		in_if.pin_a <= it.pin_a;
		in_if.pin_b <= it.pin_b;
		in_if.load_value <= it.load_value;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		want = typed ? want : decode_item(it);
		if (typed)
			void'(decode_item(it));
		predicted_readings.push_back(want);
		if (it.command == CMD_SAMPLE)
			walk_pair = {it.pin_a, it.pin_b};
		else if (it.command == CMD_LOAD)
			walk_pair = 2'b00;
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		while (predicted_readings.size() != 0) @(posedge clk);
	endtask

	// caller lowers cfg_we after its last write
	task automatic write_cfg(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_VALUE_MIN)
			lim_lo = val;
		else
			lim_hi = val;
	endtask

	// mostly gray-code walks with random direction, mixed with applies, loads and noise
	task automatic run_phase(int n_items);
		int        sent;
		int        pick;
		int        jitter;
		bit        dir;
		logic [1:0] pos;
		enc_item_t it;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				dir = $urandom_range(0, 1);
				repeat ($urandom_range(2, 8)) begin
					pos = {walk_pair[1], walk_pair[1] ^ walk_pair[0]};
					jitter = $urandom_range(0, 19);
					// jitter 0 repeats the same pair, 1 skips a phase
					if (jitter > 1)
						pos = dir ? pos + 2'd1 : pos - 2'd1;
					else if (jitter == 1)
						pos = pos + 2'd2;
					it = '{CMD_SAMPLE, pos[1], pos[1] ^ pos[0], 16'($urandom)};
					send_item(it, 1'b0, '0);
					sent++;
				end
				if ($urandom_range(0, 9) < 7) begin
					it = '{CMD_APPLY, 1'($urandom), 1'($urandom), 16'($urandom)};
					send_item(it, 1'b0, '0);
					sent++;
				end
			end else if (pick < 75) begin
				it = '{CMD_APPLY, 1'($urandom), 1'($urandom), 16'($urandom)};
				send_item(it, 1'b0, '0);
				sent++;
			end else if (pick < 85) begin
				// loads cluster around the range edges
				it = '{CMD_LOAD, 1'($urandom), 1'($urandom), 16'($urandom)};
				case ($urandom_range(0, 5))
					0: it.load_value = lim_lo;
					1: it.load_value = lim_hi;
					2: it.load_value = lim_lo - 16'sd1;
					3: it.load_value = lim_hi + 16'sd1;
					default: ;
				endcase
				send_item(it, 1'b0, '0);
				sent++;
			end else if (pick < 93) begin
				it = '{CMD_SAMPLE, 1'($urandom), 1'($urandom), 16'($urandom)};
				send_item(it, 1'b0, '0);
				sent++;
			end else begin
				it = '{CMD_SPARE, 1'($urandom), 1'($urandom), 16'($urandom)};
				send_item(it, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		enc_result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (predicted_readings.size() == 0) begin
				$error("unexpected result: pending_step %0d current_value %0d",
					$signed(out_if.pending_step), $signed(out_if.current_value));
				fault_count++;
			end else begin
				want = predicted_readings.pop_front();
				if (out_if.pending_step !== want.pending_step) begin
					$error("pending_step: expected %0d, actual %0d",
						$signed(want.pending_step), $signed(out_if.pending_step));
					fault_count++;
				end
				if (out_if.current_value !== want.current_value) begin
					$error("current_value: expected %0d, actual %0d",
						$signed(want.current_value), $signed(out_if.current_value));
					fault_count++;
				end
			end
		end
	end

	// result side: random stalls, one long hold-off while the sender keeps going
	initial begin : result_sink
		int stall;
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		out_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && taken >= 450) begin
				out_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end
			stall = (taken % 170 < 40) ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			@(posedge clk);
			while (!out_if.valid) @(posedge clk);
			taken++;
		end
	end

	// end the run when no transaction moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		enc_item_t          it;
		enc_result_t        want;
		dir_row_t           row;
		code_reg = '0;
		hist_reg = '0;
		step_reg = 2'sd0;
		count_reg = 16'sd0;
		lim_lo = 16'sd0;
		lim_hi = 16'sd127;
		walk_pair = 2'b00;
		pace_ctr = 0;
		fault_count = 0;
		arst_n <= 1'b0;
		in_if.valid <= 1'b0;
		in_if.command <= CMD_SAMPLE;
		in_if.pin_a <= 1'b0;
		in_if.pin_b <= 1'b0;
		in_if.load_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_VALUE_MIN;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				drain();
				write_cfg(row.a, row.data);
			end else begin
				cfg_we <= 1'b0;
				it = '{row.cmd, row.a, row.b, row.data};
				want = '{row.want_step, row.want_value};
				send_item(it, row.typed, want);
			end
		end

		// random phases, each under its own range
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				0: begin
					lo = -16'sd20;
					hi = 16'sd20;
				end
				1: begin
					lo = 16'sh8000;
					hi = 16'sh7fff;
				end
				2: begin
					// reversed extremes leave an empty range
					lo = 16'sh7fff;
					hi = 16'sh8000;
				end
				3: begin
					lo = 16'sd0;
					hi = 16'sd0;
				end
				4: begin
					lo = 16'($urandom);
					hi = lo + 16'($urandom_range(0, 40));
				end
				default: begin
					lo = 16'sd0;
					hi = 16'sd127;
				end
			endcase
			write_cfg(CFG_VALUE_MIN, lo);
			write_cfg(CFG_VALUE_MAX, hi);
			cfg_we <= 1'b0;
			run_phase(PHASE_ITEMS);
		end

		drain();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
